>>> rtl/sprc_pkg.sv
// ----------------------------------------------------------------------------
// sprc_pkg
// Shared types and constants of the sprite compositor: canvas geometry,
// command and operation codes, and the word passed from front to back.
// ----------------------------------------------------------------------------
package sprc_pkg;

   localparam int CANVAS_DIM  = 256;
   localparam int SPRITE_DIM  = 8;
   localparam int COORD_W     = $clog2(CANVAS_DIM);
   localparam int BOX_W       = COORD_W + 1;
   localparam int ADDR_W      = 2 * COORD_W;
   localparam int STORE_DEPTH = CANVAS_DIM * CANVAS_DIM;
   localparam int COLOR_W     = 8;
   localparam int RGB_W       = 3 * COLOR_W;
   localparam int STORE_W     = RGB_W + 1;
   localparam int CMD_W       = 2;
   localparam int POS_W       = 8;
   localparam int PIX_W       = 3;
   localparam int INDEX_W     = 8;
   localparam int REL_W       = 8;
   localparam int STATUS_W    = 2;
   localparam int CSR_IDX_W   = 2;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [BOX_W-1:0] ORIGIN_LIMIT =
      (SPRITE_DIM >= CANVAS_DIM) ? '0 : BOX_W'(CANVAS_DIM - SPRITE_DIM);
   localparam logic [BOX_W-1:0] SPRITE_SPAN  = BOX_W'(SPRITE_DIM);
   localparam logic [BOX_W-1:0] CANVAS_SPAN  = BOX_W'(CANVAS_DIM);

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OUTSIDE   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_SPRITE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_BG_RED   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BG_GREEN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BG_BLUE  = 2'd2;

   typedef enum logic [CMD_W-1:0] {
      CMD_PLACE = 2'd0,
      CMD_PIXEL = 2'd1,
      CMD_READ  = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      OP_NONE  = 2'd0,
      OP_WRITE = 2'd1,
      OP_READ  = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef struct packed {
      op_type               op;
      logic                 bg;
      logic [ADDR_W-1:0]    addr;
      logic [RGB_W-1:0]     rgb;
      logic [BOX_W-1:0]     width;
      logic [BOX_W-1:0]     height;
      logic [STATUS_W-1:0]  status;
   } entry_type;

   typedef struct packed {
      logic sweeping;
      logic sweep_done;
   } back_stat_type;

endpackage

>>> rtl/sprc_ram.sv
// ----------------------------------------------------------------------------
// sprc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sprc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/sprc_queue.sv
// ----------------------------------------------------------------------------
// sprc_queue
// Short FIFO of classified words between the front and the back.
// ----------------------------------------------------------------------------
module sprc_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  sprc_pkg::entry_type push_entry,
   input  logic                pop,
   output sprc_pkg::entry_type head_entry,
   output logic                full,
   output logic                empty
);

   sprc_pkg::entry_type               entries_ff [sprc_pkg::QUEUE_DEPTH];
   logic [sprc_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [sprc_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [sprc_pkg::QPTR_W:0]         count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_entry = entries_ff[rd_ptr_ff];
   assign full       = (count_ff == (sprc_pkg::QPTR_W + 1)'(sprc_pkg::QUEUE_DEPTH));
   assign empty      = (count_ff == '0);

endmodule

>>> rtl/sprc_front.sv
// ----------------------------------------------------------------------------
// sprc_front
// Accepts commands, keeps the bounding box and sprite origin, and turns
// each command into a store operation word for the back.
// ----------------------------------------------------------------------------
module sprc_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [sprc_pkg::CMD_W-1:0]      req_cmd,
   input  logic [sprc_pkg::POS_W-1:0]      req_pos_x,
   input  logic [sprc_pkg::POS_W-1:0]      req_pos_y,
   input  logic [sprc_pkg::PIX_W-1:0]      req_pix_row,
   input  logic [sprc_pkg::PIX_W-1:0]      req_pix_col,
   input  logic [sprc_pkg::INDEX_W-1:0]    req_color_index,
   input  logic [sprc_pkg::COLOR_W-1:0]    req_red,
   input  logic [sprc_pkg::COLOR_W-1:0]    req_green,
   input  logic [sprc_pkg::COLOR_W-1:0]    req_blue,
   input  logic [sprc_pkg::REL_W-1:0]      req_read_row,
   input  logic [sprc_pkg::REL_W-1:0]      req_read_col,
   input  logic                            q_full,
   input  sprc_pkg::back_stat_type         back_stat,
   output logic                            push,
   output sprc_pkg::entry_type             push_entry
);

   logic                               any_ff, any_in;
   logic [sprc_pkg::BOX_W-1:0]         min_x_ff, min_x_in, min_y_ff, min_y_in;
   logic [sprc_pkg::BOX_W-1:0]         max_x_ff, max_x_in, max_y_ff, max_y_in;
   logic [sprc_pkg::COORD_W-1:0]       org_x_ff, org_x_in, org_y_ff, org_y_in;
   logic                               clear_wait_ff, clear_wait_in;

   logic                               accept;
   sprc_pkg::cmd_type                  cmd;
   logic [sprc_pkg::BOX_W-1:0]         ox, oy, ex, ey;
   logic [sprc_pkg::BOX_W-1:0]         n_min_x, n_min_y, n_max_x, n_max_y;
   logic [sprc_pkg::BOX_W-1:0]         cur_w, cur_h;
   logic [sprc_pkg::BOX_W-1:0]         pix_tx, pix_ty, rd_tx, rd_ty;
   logic [sprc_pkg::BOX_W-1:0]         pr, pc, rr, rc;

   assign req_ready = !q_full && !back_stat.sweeping && !clear_wait_ff;
   assign accept    = req_valid && req_ready;
   assign push      = accept;
   assign cmd       = sprc_pkg::cmd_type'(req_cmd);

   // origin clamp, box growth, current box size and pixel and read targets
   always_comb begin
      ox = (sprc_pkg::BOX_W'(req_pos_x) > sprc_pkg::ORIGIN_LIMIT) ?
           sprc_pkg::ORIGIN_LIMIT : sprc_pkg::BOX_W'(req_pos_x);
      oy = (sprc_pkg::BOX_W'(req_pos_y) > sprc_pkg::ORIGIN_LIMIT) ?
           sprc_pkg::ORIGIN_LIMIT : sprc_pkg::BOX_W'(req_pos_y);
      ex = ox + sprc_pkg::SPRITE_SPAN;
      ey = oy + sprc_pkg::SPRITE_SPAN;
      if (any_ff) begin
         n_min_x = (ox < min_x_ff) ? ox : min_x_ff;
         n_min_y = (oy < min_y_ff) ? oy : min_y_ff;
         n_max_x = (ex > max_x_ff) ? ex : max_x_ff;
         n_max_y = (ey > max_y_ff) ? ey : max_y_ff;
      end else begin
         n_min_x = ox;
         n_min_y = oy;
         n_max_x = ex;
         n_max_y = ey;
      end
      cur_w  = any_ff ? max_x_ff - min_x_ff : '0;
      cur_h  = any_ff ? max_y_ff - min_y_ff : '0;
      pr     = sprc_pkg::BOX_W'(req_pix_row);
      pc     = sprc_pkg::BOX_W'(req_pix_col);
      rr     = sprc_pkg::BOX_W'(req_read_row);
      rc     = sprc_pkg::BOX_W'(req_read_col);
      pix_tx = sprc_pkg::BOX_W'(org_x_ff) + pc;
      pix_ty = sprc_pkg::BOX_W'(org_y_ff) + pr;
      rd_tx  = min_x_ff + rc;
      rd_ty  = min_y_ff + rr;
   end

   always_comb begin
      any_in        = any_ff;
      min_x_in      = min_x_ff;
      min_y_in      = min_y_ff;
      max_x_in      = max_x_ff;
      max_y_in      = max_y_ff;
      org_x_in      = org_x_ff;
      org_y_in      = org_y_ff;
      clear_wait_in = clear_wait_ff && !back_stat.sweep_done;

      push_entry        = '0;
      push_entry.op     = sprc_pkg::OP_NONE;
      push_entry.rgb    = {req_red, req_green, req_blue};
      push_entry.width  = cur_w;
      push_entry.height = cur_h;
      push_entry.status = sprc_pkg::STATUS_OK;

      unique case (cmd)
         sprc_pkg::CMD_PLACE: begin
            push_entry.width  = n_max_x - n_min_x;
            push_entry.height = n_max_y - n_min_y;
            if (accept) begin
               any_in   = 1'b1;
               min_x_in = n_min_x;
               min_y_in = n_min_y;
               max_x_in = n_max_x;
               max_y_in = n_max_y;
               org_x_in = sprc_pkg::COORD_W'(ox);
               org_y_in = sprc_pkg::COORD_W'(oy);
            end
         end
         sprc_pkg::CMD_PIXEL: begin
            push_entry.addr = {pix_ty[sprc_pkg::COORD_W-1:0],
                               pix_tx[sprc_pkg::COORD_W-1:0]};
            if (!any_ff) begin
               push_entry.status = sprc_pkg::STATUS_NO_SPRITE;
            end else if (req_color_index != '0 && pr < sprc_pkg::SPRITE_SPAN &&
                         pc < sprc_pkg::SPRITE_SPAN && pix_tx < sprc_pkg::CANVAS_SPAN &&
                         pix_ty < sprc_pkg::CANVAS_SPAN) begin
               push_entry.op = sprc_pkg::OP_WRITE;
            end
         end
         sprc_pkg::CMD_READ: begin
            push_entry.bg   = 1'b1;
            push_entry.addr = {rd_ty[sprc_pkg::COORD_W-1:0],
                               rd_tx[sprc_pkg::COORD_W-1:0]};
            if (!any_ff || rr >= cur_h || rc >= cur_w) begin
               push_entry.status = sprc_pkg::STATUS_OUTSIDE;
            end else if (rd_tx < sprc_pkg::CANVAS_SPAN && rd_ty < sprc_pkg::CANVAS_SPAN) begin
               push_entry.op = sprc_pkg::OP_READ;
            end
         end
         sprc_pkg::CMD_CLEAR: begin
            push_entry.op     = sprc_pkg::OP_CLEAR;
            push_entry.width  = '0;
            push_entry.height = '0;
            if (accept) begin
               any_in        = 1'b0;
               min_x_in      = '0;
               min_y_in      = '0;
               max_x_in      = '0;
               max_y_in      = '0;
               org_x_in      = '0;
               org_y_in      = '0;
               clear_wait_in = 1'b1;
            end
         end
         default: begin
            push_entry.op = sprc_pkg::OP_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         any_ff        <= 1'b0;
         min_x_ff      <= '0;
         min_y_ff      <= '0;
         max_x_ff      <= '0;
         max_y_ff      <= '0;
         org_x_ff      <= '0;
         org_y_ff      <= '0;
         clear_wait_ff <= 1'b0;
      end else begin
         any_ff        <= any_in;
         min_x_ff      <= min_x_in;
         min_y_ff      <= min_y_in;
         max_x_ff      <= max_x_in;
         max_y_ff      <= max_y_in;
         org_x_ff      <= org_x_in;
         org_y_ff      <= org_y_in;
         clear_wait_ff <= clear_wait_in;
      end
   end

endmodule

>>> rtl/sprc_back.sv
// ----------------------------------------------------------------------------
// sprc_back
// Executes store operations on the frame store, runs the clearing sweep
// and holds the response register.
// ----------------------------------------------------------------------------
module sprc_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_empty,
   input  sprc_pkg::entry_type             head_entry,
   output logic                            pop,
   output sprc_pkg::back_stat_type         back_stat,
   input  logic [sprc_pkg::COLOR_W-1:0]    bg_red,
   input  logic [sprc_pkg::COLOR_W-1:0]    bg_green,
   input  logic [sprc_pkg::COLOR_W-1:0]    bg_blue,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [sprc_pkg::COLOR_W-1:0]    rsp_out_red,
   output logic [sprc_pkg::COLOR_W-1:0]    rsp_out_green,
   output logic [sprc_pkg::COLOR_W-1:0]    rsp_out_blue,
   output logic [sprc_pkg::BOX_W-1:0]      rsp_image_width,
   output logic [sprc_pkg::BOX_W-1:0]      rsp_image_height,
   output logic [sprc_pkg::STATUS_W-1:0]   rsp_status
);

   logic                               sweeping_ff, sweeping_in;
   logic [sprc_pkg::ADDR_W-1:0]        sweep_addr_ff, sweep_addr_in;
   logic                               sweep_last;

   logic                               p_valid_ff, p_valid_in;
   sprc_pkg::entry_type                p_entry_ff;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [sprc_pkg::RGB_W-1:0]         rsp_rgb_ff, rsp_rgb_in;
   logic [sprc_pkg::BOX_W-1:0]         rsp_w_ff, rsp_h_ff;
   logic [sprc_pkg::STATUS_W-1:0]      rsp_status_ff;

   logic                               move_p;
   logic                               ram_we, ram_re;
   logic [sprc_pkg::ADDR_W-1:0]        ram_waddr;
   logic [sprc_pkg::STORE_W-1:0]       ram_wdata, ram_rdata;
   logic [sprc_pkg::RGB_W-1:0]         bg_rgb;

   assign bg_rgb     = {bg_red, bg_green, bg_blue};
   assign sweep_last = (sweep_addr_ff == '1);
   assign move_p     = p_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign pop        = !q_empty && !sweeping_ff && (!p_valid_ff || move_p);

   assign back_stat.sweeping   = sweeping_ff;
   assign back_stat.sweep_done = sweeping_ff && sweep_last;

   // sweep owns the write port; no word is taken meanwhile
   always_comb begin
      ram_we    = sweeping_ff || (pop && head_entry.op == sprc_pkg::OP_WRITE);
      ram_waddr = sweeping_ff ? sweep_addr_ff : head_entry.addr;
      ram_wdata = sweeping_ff ? '0 : {1'b1, head_entry.rgb};
      ram_re    = pop && head_entry.op == sprc_pkg::OP_READ;
   end

   sprc_ram #(
      .WIDTH (sprc_pkg::STORE_W),
      .DEPTH (sprc_pkg::STORE_DEPTH)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (head_entry.addr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      sweeping_in   = sweeping_ff;
      sweep_addr_in = sweep_addr_ff;
      if (sweeping_ff) begin
         sweep_addr_in = sweep_addr_ff + 1'b1;
         if (sweep_last) begin
            sweeping_in = 1'b0;
         end
      end else if (pop && head_entry.op == sprc_pkg::OP_CLEAR) begin
         sweeping_in   = 1'b1;
         sweep_addr_in = '0;
      end

      if (pop) begin
         p_valid_in = 1'b1;
      end else if (move_p) begin
         p_valid_in = 1'b0;
      end else begin
         p_valid_in = p_valid_ff;
      end

      if (move_p) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      if (p_entry_ff.op == sprc_pkg::OP_READ) begin
         rsp_rgb_in = ram_rdata[sprc_pkg::RGB_W] ?
                      ram_rdata[sprc_pkg::RGB_W-1:0] : bg_rgb;
      end else if (p_entry_ff.bg) begin
         rsp_rgb_in = bg_rgb;
      end else begin
         rsp_rgb_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweeping_ff   <= 1'b1;
         sweep_addr_ff <= '0;
         p_valid_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         sweeping_ff   <= sweeping_in;
         sweep_addr_ff <= sweep_addr_in;
         p_valid_ff    <= p_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         p_entry_ff <= head_entry;
      end
      if (move_p) begin
         rsp_rgb_ff    <= rsp_rgb_in;
         rsp_w_ff      <= p_entry_ff.width;
         rsp_h_ff      <= p_entry_ff.height;
         rsp_status_ff <= p_entry_ff.status;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_red      = rsp_rgb_ff[3*sprc_pkg::COLOR_W-1:2*sprc_pkg::COLOR_W];
   assign rsp_out_green    = rsp_rgb_ff[2*sprc_pkg::COLOR_W-1:sprc_pkg::COLOR_W];
   assign rsp_out_blue     = rsp_rgb_ff[sprc_pkg::COLOR_W-1:0];
   assign rsp_image_width  = rsp_w_ff;
   assign rsp_image_height = rsp_h_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

>>> rtl/sprite_compositor_with_bounding_box_unit.sv
// ----------------------------------------------------------------------------
// sprite_compositor_with_bounding_box_unit
// Composites 8x8 sprites with a transparent color key onto a 256x256 frame
// store and reads pixels back relative to the growing bounding box.
//
// Commands arrive on the req_ channel (valid/ready): place, sprite pixel,
// read pixel and clear frame. Every command gives exactly one word on the
// rsp_ channel (valid/ready) with the read color, the box size and a status.
// Background color registers are written through csr_we/csr_index/csr_wdata;
// the user must do so only while the unit is idle, not enforced by the block.
// Throughput is one command per cycle unless the queue is full or a clear
// or sweep holds req_ready low. A four-deep queue separates the command
// front end from the frame store port, so a stalled rsp_ready fills the
// queue and then drops req_ready without losing any word. Reset and every
// clear command start a sweep of the frame store, one entry per cycle over
// all 65536 entries, during which req_ready stays low; background registers
// keep their values across a clear and reset to zero.
// ----------------------------------------------------------------------------
module sprite_compositor_with_bounding_box_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [sprc_pkg::CMD_W-1:0]       req_cmd,
   input  logic [sprc_pkg::POS_W-1:0]       req_pos_x,
   input  logic [sprc_pkg::POS_W-1:0]       req_pos_y,
   input  logic [sprc_pkg::PIX_W-1:0]       req_pix_row,
   input  logic [sprc_pkg::PIX_W-1:0]       req_pix_col,
   input  logic [sprc_pkg::INDEX_W-1:0]     req_color_index,
   input  logic [sprc_pkg::COLOR_W-1:0]     req_red,
   input  logic [sprc_pkg::COLOR_W-1:0]     req_green,
   input  logic [sprc_pkg::COLOR_W-1:0]     req_blue,
   input  logic [sprc_pkg::REL_W-1:0]       req_read_row,
   input  logic [sprc_pkg::REL_W-1:0]       req_read_col,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [sprc_pkg::COLOR_W-1:0]     rsp_out_red,
   output logic [sprc_pkg::COLOR_W-1:0]     rsp_out_green,
   output logic [sprc_pkg::COLOR_W-1:0]     rsp_out_blue,
   output logic [sprc_pkg::BOX_W-1:0]       rsp_image_width,
   output logic [sprc_pkg::BOX_W-1:0]       rsp_image_height,
   output logic [sprc_pkg::STATUS_W-1:0]    rsp_status,
   input  logic                             csr_we,
   input  logic [sprc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sprc_pkg::COLOR_W-1:0]     csr_wdata
);

   logic [sprc_pkg::COLOR_W-1:0]  bg_red_ff, bg_red_in;
   logic [sprc_pkg::COLOR_W-1:0]  bg_green_ff, bg_green_in;
   logic [sprc_pkg::COLOR_W-1:0]  bg_blue_ff, bg_blue_in;

   logic                          push, pop, q_full, q_empty;
   sprc_pkg::entry_type           push_entry, head_entry;
   sprc_pkg::back_stat_type       back_stat;

   always_comb begin
      bg_red_in   = bg_red_ff;
      bg_green_in = bg_green_ff;
      bg_blue_in  = bg_blue_ff;
      if (csr_we) begin
         unique case (csr_index)
            sprc_pkg::CSR_BG_RED:   bg_red_in   = csr_wdata;
            sprc_pkg::CSR_BG_GREEN: bg_green_in = csr_wdata;
            sprc_pkg::CSR_BG_BLUE:  bg_blue_in  = csr_wdata;
            default: begin
               bg_red_in = bg_red_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bg_red_ff   <= '0;
         bg_green_ff <= '0;
         bg_blue_ff  <= '0;
      end else begin
         bg_red_ff   <= bg_red_in;
         bg_green_ff <= bg_green_in;
         bg_blue_ff  <= bg_blue_in;
      end
   end

   sprc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_pix_row     (req_pix_row),
      .req_pix_col     (req_pix_col),
      .req_color_index (req_color_index),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .req_read_row    (req_read_row),
      .req_read_col    (req_read_col),
      .q_full          (q_full),
      .back_stat       (back_stat),
      .push            (push),
      .push_entry      (push_entry)
   );

   sprc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .full       (q_full),
      .empty      (q_empty)
   );

   sprc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .head_entry       (head_entry),
      .pop              (pop),
      .back_stat        (back_stat),
      .bg_red           (bg_red_ff),
      .bg_green         (bg_green_ff),
      .bg_blue          (bg_blue_ff),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_red      (rsp_out_red),
      .rsp_out_green    (rsp_out_green),
      .rsp_out_blue     (rsp_out_blue),
      .rsp_image_width  (rsp_image_width),
      .rsp_image_height (rsp_image_height),
      .rsp_status       (rsp_status)
   );

endmodule

>>> verif/sprite_compositor_with_bounding_box_unit_tb.sv
// ----------------------------------------------------------------------------
// sprite_compositor_with_bounding_box_unit_tb
// Self-checking bench for the sprite compositor. A short scripted run covers
// the first read, pixels before any place, saturated origins, transparent
// pixels, reads on the box edges and a clear. Four phases of random command
// streams follow, each under its own background color. Every accepted
// command goes through a behavioral copy of the compositor. Each response
// word is compared field by field while both channels stall at random.
// ----------------------------------------------------------------------------
module sprite_compositor_with_bounding_box_unit_tb;

   localparam int unsigned WATCHDOG_LIMIT = 300000;
   localparam int          PHASE_ITEMS    = 332;
   localparam int          PHASES         = 4;
   localparam int          MAX_CLEARS     = 4;
   localparam int          SCRIPT_LEN     = 25;
   localparam logic [sprc_pkg::COLOR_W-1:0] BG_R0 = 8'hA5;
   localparam logic [sprc_pkg::COLOR_W-1:0] BG_G0 = 8'h5A;
   localparam logic [sprc_pkg::COLOR_W-1:0] BG_B0 = 8'h3C;
   localparam logic [sprc_pkg::RGB_W-1:0]   BG0   = {BG_R0, BG_G0, BG_B0};

   typedef struct packed {
      logic [sprc_pkg::COLOR_W-1:0]  red;
      logic [sprc_pkg::COLOR_W-1:0]  green;
      logic [sprc_pkg::COLOR_W-1:0]  blue;
      logic [sprc_pkg::BOX_W-1:0]    width;
      logic [sprc_pkg::BOX_W-1:0]    height;
      logic [sprc_pkg::STATUS_W-1:0] status;
   } rsp_word_type;

   typedef struct {
      sprc_pkg::cmd_type            cmd;
      logic [sprc_pkg::POS_W-1:0]   pos_x;
      logic [sprc_pkg::POS_W-1:0]   pos_y;
      logic [sprc_pkg::PIX_W-1:0]   pix_row;
      logic [sprc_pkg::PIX_W-1:0]   pix_col;
      logic [sprc_pkg::INDEX_W-1:0] color_index;
      logic [sprc_pkg::COLOR_W-1:0] red;
      logic [sprc_pkg::COLOR_W-1:0] green;
      logic [sprc_pkg::COLOR_W-1:0] blue;
      logic [sprc_pkg::REL_W-1:0]   read_row;
      logic [sprc_pkg::REL_W-1:0]   read_col;
   } req_word_type;

   typedef struct {
      sprc_pkg::cmd_type            cmd;
      logic [7:0]                   a;
      logic [7:0]                   b;
      logic [sprc_pkg::INDEX_W-1:0] color_index;
      logic [sprc_pkg::RGB_W-1:0]   rgb;
      logic                         typed;
      rsp_word_type                 want;
   } script_row_type;

   localparam rsp_word_type NO_WANT = '0;

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             req_valid;
   logic                             req_ready;
   logic [sprc_pkg::CMD_W-1:0]       req_cmd;
   logic [sprc_pkg::POS_W-1:0]       req_pos_x;
   logic [sprc_pkg::POS_W-1:0]       req_pos_y;
   logic [sprc_pkg::PIX_W-1:0]       req_pix_row;
   logic [sprc_pkg::PIX_W-1:0]       req_pix_col;
   logic [sprc_pkg::INDEX_W-1:0]     req_color_index;
   logic [sprc_pkg::COLOR_W-1:0]     req_red;
   logic [sprc_pkg::COLOR_W-1:0]     req_green;
   logic [sprc_pkg::COLOR_W-1:0]     req_blue;
   logic [sprc_pkg::REL_W-1:0]       req_read_row;
   logic [sprc_pkg::REL_W-1:0]       req_read_col;
   logic                             rsp_valid;
   logic                             rsp_ready;
   logic [sprc_pkg::COLOR_W-1:0]     rsp_out_red;
   logic [sprc_pkg::COLOR_W-1:0]     rsp_out_green;
   logic [sprc_pkg::COLOR_W-1:0]     rsp_out_blue;
   logic [sprc_pkg::BOX_W-1:0]       rsp_image_width;
   logic [sprc_pkg::BOX_W-1:0]       rsp_image_height;
   logic [sprc_pkg::STATUS_W-1:0]    rsp_status;
   logic                             csr_we;
   logic [sprc_pkg::CSR_IDX_W-1:0]   csr_index;
   logic [sprc_pkg::COLOR_W-1:0]     csr_wdata;

   // behavioral copy of the compositor
   logic                             canvas_drawn [sprc_pkg::STORE_DEPTH];
   logic [sprc_pkg::RGB_W-1:0]       canvas_rgb   [sprc_pkg::STORE_DEPTH];
   logic [sprc_pkg::BOX_W-1:0]       box_x_lo, box_y_lo, box_x_hi, box_y_hi;
   logic                             box_used;
   logic [sprc_pkg::COORD_W-1:0]     org_x, org_y;
   logic [sprc_pkg::COLOR_W-1:0]     bg_red, bg_green, bg_blue;

   rsp_word_type           pending_pixels [$];
   int unsigned            req_taken    = 0;
   int unsigned            rsp_taken    = 0;
   int unsigned            quiet_cycles = 0;
   int unsigned            mismatches   = 0;
   int unsigned            clears_drawn = 0;
   logic                   no_stall;
   logic                   typed_now;
   rsp_word_type           typed_want;

   sprite_compositor_with_bounding_box_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pix_row      (req_pix_row),
      .req_pix_col      (req_pix_col),
      .req_color_index  (req_color_index),
      .req_red          (req_red),
      .req_green        (req_green),
      .req_blue         (req_blue),
      .req_read_row     (req_read_row),
      .req_read_col     (req_read_col),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_red      (rsp_out_red),
      .rsp_out_green    (rsp_out_green),
      .rsp_out_blue     (rsp_out_blue),
      .rsp_image_width  (rsp_image_width),
      .rsp_image_height (rsp_image_height),
      .rsp_status       (rsp_status),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void wipe_frame();
      foreach (canvas_drawn[i]) canvas_drawn[i] = 1'b0;
      box_x_lo = '0;
      box_y_lo = '0;
      box_x_hi = '0;
      box_y_hi = '0;
      box_used = 1'b0;
      org_x    = '0;
      org_y    = '0;
   endfunction

   function automatic logic [sprc_pkg::BOX_W-1:0] saturate_origin(
      input logic [sprc_pkg::POS_W-1:0] p);
      return (sprc_pkg::BOX_W'(p) > sprc_pkg::ORIGIN_LIMIT) ?
             sprc_pkg::ORIGIN_LIMIT : sprc_pkg::BOX_W'(p);
   endfunction

   function automatic rsp_word_type composite_step(input req_word_type w);
      rsp_word_type                  o;
      logic [sprc_pkg::BOX_W-1:0]    ox, oy, tx, ty, cw, ch;
      logic [sprc_pkg::ADDR_W-1:0]   addr;
      o  = '0;
      cw = box_used ? box_x_hi - box_x_lo : '0;
      ch = box_used ? box_y_hi - box_y_lo : '0;
      case (w.cmd)
         sprc_pkg::CMD_PLACE: begin
            ox    = saturate_origin(w.pos_x);
            oy    = saturate_origin(w.pos_y);
            org_x = ox[sprc_pkg::COORD_W-1:0];
            org_y = oy[sprc_pkg::COORD_W-1:0];
            if (!box_used || ox < box_x_lo) box_x_lo = ox;
            if (!box_used || oy < box_y_lo) box_y_lo = oy;
            if (!box_used || ox + sprc_pkg::SPRITE_SPAN > box_x_hi)
               box_x_hi = ox + sprc_pkg::SPRITE_SPAN;
            if (!box_used || oy + sprc_pkg::SPRITE_SPAN > box_y_hi)
               box_y_hi = oy + sprc_pkg::SPRITE_SPAN;
            box_used = 1'b1;
         end
         sprc_pkg::CMD_PIXEL: begin
            if (!box_used) begin
               o.status = sprc_pkg::STATUS_NO_SPRITE;
            end else if (w.color_index != '0) begin
               tx   = sprc_pkg::BOX_W'(org_x) + sprc_pkg::BOX_W'(w.pix_col);
               ty   = sprc_pkg::BOX_W'(org_y) + sprc_pkg::BOX_W'(w.pix_row);
               addr = {ty[sprc_pkg::COORD_W-1:0], tx[sprc_pkg::COORD_W-1:0]};
               if (tx < sprc_pkg::CANVAS_SPAN && ty < sprc_pkg::CANVAS_SPAN) begin
                  canvas_drawn[addr] = 1'b1;
                  canvas_rgb[addr]   = {w.red, w.green, w.blue};
               end
            end
         end
         sprc_pkg::CMD_READ: begin
            o.red   = bg_red;
            o.green = bg_green;
            o.blue  = bg_blue;
            if (!box_used || sprc_pkg::BOX_W'(w.read_row) >= ch ||
                sprc_pkg::BOX_W'(w.read_col) >= cw) begin
               o.status = sprc_pkg::STATUS_OUTSIDE;
            end else begin
               ty   = box_y_lo + sprc_pkg::BOX_W'(w.read_row);
               tx   = box_x_lo + sprc_pkg::BOX_W'(w.read_col);
               addr = {ty[sprc_pkg::COORD_W-1:0], tx[sprc_pkg::COORD_W-1:0]};
               if (tx < sprc_pkg::CANVAS_SPAN && ty < sprc_pkg::CANVAS_SPAN &&
                   canvas_drawn[addr])
                  {o.red, o.green, o.blue} = canvas_rgb[addr];
            end
         end
         sprc_pkg::CMD_CLEAR: begin
            wipe_frame();
         end
      endcase
      o.width  = box_used ? box_x_hi - box_x_lo : '0;
      o.height = box_used ? box_y_hi - box_y_lo : '0;
      return o;
   endfunction

   task automatic flag_mismatch(input string msg);
      mismatches++;
      $display("mismatch at word %0d: %s", rsp_taken, msg);
   endtask

   always @(posedge clock) begin
      req_word_type seen;
      rsp_word_type got, want;
      if (!reset) begin
         quiet_cycles++;
         if (csr_we) begin
            case (csr_index)
               sprc_pkg::CSR_BG_RED:   bg_red   = csr_wdata;
               sprc_pkg::CSR_BG_GREEN: bg_green = csr_wdata;
               sprc_pkg::CSR_BG_BLUE:  bg_blue  = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            got = {rsp_out_red, rsp_out_green, rsp_out_blue,
                   rsp_image_width, rsp_image_height, rsp_status};
            if (pending_pixels.size() == 0) begin
               flag_mismatch("word with nothing pending");
            end else begin
               want = pending_pixels.pop_front();
               if (got.red != want.red)
                  flag_mismatch($sformatf("out_red %0d, want %0d", got.red, want.red));
               if (got.green != want.green)
                  flag_mismatch($sformatf("out_green %0d, want %0d", got.green, want.green));
               if (got.blue != want.blue)
                  flag_mismatch($sformatf("out_blue %0d, want %0d", got.blue, want.blue));
               if (got.width != want.width)
                  flag_mismatch($sformatf("image_width %0d, want %0d", got.width, want.width));
               if (got.height != want.height)
                  flag_mismatch($sformatf("image_height %0d, want %0d",
                                          got.height, want.height));
               if (got.status != want.status)
                  flag_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
            end
            rsp_taken++;
            quiet_cycles = 0;
         end
         if (req_valid && req_ready) begin
            seen.cmd         = sprc_pkg::cmd_type'(req_cmd);
            seen.pos_x       = req_pos_x;
            seen.pos_y       = req_pos_y;
            seen.pix_row     = req_pix_row;
            seen.pix_col     = req_pix_col;
            seen.color_index = req_color_index;
            seen.red         = req_red;
            seen.green       = req_green;
            seen.blue        = req_blue;
            seen.read_row    = req_read_row;
            seen.read_col    = req_read_col;
            want = composite_step(seen);
            if (typed_now) want = typed_want;
            pending_pixels = {pending_pixels, want};
            req_taken++;
            quiet_cycles = 0;
         end
      end
   end

   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   // response side
   initial begin
      int unsigned gap, mark;
      rsp_ready = 1'b0;
      forever begin
         gap = no_stall ? 0 : $urandom_range(0, 16);
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         mark = rsp_taken;
         do @(negedge clock); while (rsp_taken == mark);
      end
   end

   function automatic req_word_type random_word();
      req_word_type w;
      w.cmd         = sprc_pkg::cmd_type'($urandom_range(0, 3));
      w.pos_x       = sprc_pkg::POS_W'($urandom);
      w.pos_y       = sprc_pkg::POS_W'($urandom);
      w.pix_row     = sprc_pkg::PIX_W'($urandom);
      w.pix_col     = sprc_pkg::PIX_W'($urandom);
      w.color_index = sprc_pkg::INDEX_W'($urandom);
      w.red         = sprc_pkg::COLOR_W'($urandom);
      w.green       = sprc_pkg::COLOR_W'($urandom);
      w.blue        = sprc_pkg::COLOR_W'($urandom);
      w.read_row    = sprc_pkg::REL_W'($urandom);
      w.read_col    = sprc_pkg::REL_W'($urandom);
      return w;
   endfunction

   function automatic req_word_type draw_command();
      req_word_type               w;
      int unsigned                pick;
      logic [sprc_pkg::BOX_W-1:0] cw, ch;
      w    = random_word();
      pick = $urandom_range(0, 99);
      if (clears_drawn < MAX_CLEARS && $urandom_range(0, 299) == 0) begin
         w.cmd = sprc_pkg::CMD_CLEAR;
         clears_drawn++;
      end else if (pick < 10) begin
         w.cmd = sprc_pkg::CMD_PLACE;
         if ($urandom_range(0, 7) == 0) w.pos_x = sprc_pkg::POS_W'($urandom_range(240, 255));
         if ($urandom_range(0, 7) == 0) w.pos_y = sprc_pkg::POS_W'($urandom_range(240, 255));
      end else if (pick < 55) begin
         w.cmd = sprc_pkg::CMD_PIXEL;
         if ($urandom_range(0, 7) == 0) w.color_index = '0;
      end else begin
         w.cmd = sprc_pkg::CMD_READ;
         cw    = box_used ? box_x_hi - box_x_lo : '0;
         ch    = box_used ? box_y_hi - box_y_lo : '0;
         pick  = $urandom_range(0, 3);
         if (pick < 2) begin
            // aim at the sprite placed last
            w.read_row = sprc_pkg::REL_W'(sprc_pkg::BOX_W'(org_y) +
                                          $urandom_range(0, 7) - box_y_lo);
            w.read_col = sprc_pkg::REL_W'(sprc_pkg::BOX_W'(org_x) +
                                          $urandom_range(0, 7) - box_x_lo);
         end else if (pick == 2 && box_used) begin
            w.read_row = sprc_pkg::REL_W'($urandom_range(0, ch));
            w.read_col = sprc_pkg::REL_W'($urandom_range(0, cw));
         end
      end
      return w;
   endfunction

   task automatic send_word(input req_word_type w, input logic typed,
                            input rsp_word_type want);
      int unsigned gap, mark;
      gap = no_stall ? 0 : $urandom_range(0, 16);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_cmd         <= w.cmd;
      req_pos_x       <= w.pos_x;
      req_pos_y       <= w.pos_y;
      req_pix_row     <= w.pix_row;
      req_pix_col     <= w.pix_col;
      req_color_index <= w.color_index;
      req_red         <= w.red;
      req_green       <= w.green;
      req_blue        <= w.blue;
      req_read_row    <= w.read_row;
      req_read_col    <= w.read_col;
      typed_now       <= typed;
      typed_want      <= want;
      req_valid       <= 1'b1;
      mark = req_taken;
      do @(negedge clock); while (req_taken == mark);
   endtask

   // drain, let the block go idle, then load a background color
   task automatic settle_and_write(input logic [sprc_pkg::COLOR_W-1:0] r, g, b);
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      while (!req_ready) @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= sprc_pkg::CSR_BG_RED;
      csr_wdata <= r;
      @(negedge clock);
      csr_index <= sprc_pkg::CSR_BG_GREEN;
      csr_wdata <= g;
      @(negedge clock);
      csr_index <= sprc_pkg::CSR_BG_BLUE;
      csr_wdata <= b;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin
      script_row_type rows [SCRIPT_LEN];
      req_word_type   w;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_cmd         = sprc_pkg::CMD_PLACE;
      req_pos_x       = '0;
      req_pos_y       = '0;
      req_pix_row     = '0;
      req_pix_col     = '0;
      req_color_index = '0;
      req_red         = '0;
      req_green       = '0;
      req_blue        = '0;
      req_read_row    = '0;
      req_read_col    = '0;
      csr_we          = 1'b0;
      csr_index       = sprc_pkg::CSR_BG_RED;
      csr_wdata       = '0;
      typed_now       = 1'b0;
      typed_want      = NO_WANT;
      no_stall        = 1'b0;
      bg_red          = '0;
      bg_green        = '0;
      bg_blue         = '0;
      wipe_frame();

      rows = '{
         '{sprc_pkg::CMD_READ,  8'd0,   8'd0,   8'd0,   24'h0,      1'b1,
           {BG0, 9'd0, 9'd0, sprc_pkg::STATUS_OUTSIDE}},
         '{sprc_pkg::CMD_PIXEL, 8'd3,   8'd4,   8'd7,   24'h123456, 1'b1,
           {24'h0, 9'd0, 9'd0, sprc_pkg::STATUS_NO_SPRITE}},
         '{sprc_pkg::CMD_PLACE, 8'd0,   8'd0,   8'd0,   24'h0,      1'b1,
           {24'h0, 9'd8, 9'd8, sprc_pkg::STATUS_OK}},
         '{sprc_pkg::CMD_PIXEL, 8'd0,   8'd0,   8'd255, 24'hFFFFFF, 1'b1,
           {24'h0, 9'd8, 9'd8, sprc_pkg::STATUS_OK}},
         '{sprc_pkg::CMD_PIXEL, 8'd7,   8'd7,   8'd0,   24'h112233, 1'b1,
           {24'h0, 9'd8, 9'd8, sprc_pkg::STATUS_OK}},
         '{sprc_pkg::CMD_READ,  8'd0,   8'd0,   8'd0,   24'h0,      1'b1,
           {24'hFFFFFF, 9'd8, 9'd8, sprc_pkg::STATUS_OK}},
         '{sprc_pkg::CMD_READ,  8'd7,   8'd7,   8'd0,   24'h0,      1'b1,
           {BG0, 9'd8, 9'd8, sprc_pkg::STATUS_OK}},
         '{sprc_pkg::CMD_READ,  8'd8,   8'd0,   8'd0,   24'h0,      1'b1,
           {BG0, 9'd8, 9'd8, sprc_pkg::STATUS_OUTSIDE}},
         '{sprc_pkg::CMD_READ,  8'd0,   8'd8,   8'd0,   24'h0,      1'b1,
           {BG0, 9'd8, 9'd8, sprc_pkg::STATUS_OUTSIDE}},
         '{sprc_pkg::CMD_PLACE, 8'd255, 8'd255, 8'd0,   24'h0,      1'b1,
           {24'h0, 9'd256, 9'd256, sprc_pkg::STATUS_OK}},
         '{sprc_pkg::CMD_PIXEL, 8'd7,   8'd7,   8'd1,   24'h000000, 1'b1,
           {24'h0, 9'd256, 9'd256, sprc_pkg::STATUS_OK}},
         '{sprc_pkg::CMD_READ,  8'd255, 8'd255, 8'd0,   24'h0,      1'b1,
           {24'h0, 9'd256, 9'd256, sprc_pkg::STATUS_OK}},
         '{sprc_pkg::CMD_READ,  8'd255, 8'd0,   8'd0,   24'h0,      1'b1,
           {BG0, 9'd256, 9'd256, sprc_pkg::STATUS_OK}},
         '{sprc_pkg::CMD_PLACE, 8'd100, 8'd37,  8'd0,   24'h0,      1'b0, NO_WANT},
         '{sprc_pkg::CMD_PIXEL, 8'd3,   8'd5,   8'd128, 24'h5AA5C3, 1'b0, NO_WANT},
         '{sprc_pkg::CMD_READ,  8'd40,  8'd105, 8'd0,   24'h0,      1'b0, NO_WANT},
         '{sprc_pkg::CMD_CLEAR, 8'd0,   8'd0,   8'd0,   24'h0,      1'b1,
           {24'h0, 9'd0, 9'd0, sprc_pkg::STATUS_OK}},
         '{sprc_pkg::CMD_READ,  8'd0,   8'd0,   8'd0,   24'h0,      1'b1,
           {BG0, 9'd0, 9'd0, sprc_pkg::STATUS_OUTSIDE}},
         '{sprc_pkg::CMD_PIXEL, 8'd0,   8'd0,   8'd9,   24'hABCDEF, 1'b1,
           {24'h0, 9'd0, 9'd0, sprc_pkg::STATUS_NO_SPRITE}},
         '{sprc_pkg::CMD_PLACE, 8'd247, 8'd0,   8'd0,   24'h0,      1'b1,
           {24'h0, 9'd8, 9'd8, sprc_pkg::STATUS_OK}},
         '{sprc_pkg::CMD_PLACE, 8'd0,   8'd247, 8'd0,   24'h0,      1'b1,
           {24'h0, 9'd255, 9'd255, sprc_pkg::STATUS_OK}},
         '{sprc_pkg::CMD_PIXEL, 8'd7,   8'd7,   8'd200, 24'hA1B2C3, 1'b0, NO_WANT},
         '{sprc_pkg::CMD_READ,  8'd254, 8'd7,   8'd0,   24'h0,      1'b0, NO_WANT},
         '{sprc_pkg::CMD_READ,  8'd255, 8'd0,   8'd0,   24'h0,      1'b0, NO_WANT},
         '{sprc_pkg::CMD_READ,  8'd0,   8'd255, 8'd0,   24'h0,      1'b0, NO_WANT}
      };

      repeat (6) @(negedge clock);
      reset <= 1'b0;
      settle_and_write(BG_R0, BG_G0, BG_B0);

      foreach (rows[i]) begin
         w     = random_word();
         w.cmd = rows[i].cmd;
         case (rows[i].cmd)
            sprc_pkg::CMD_PLACE: begin
               w.pos_x = rows[i].a;
               w.pos_y = rows[i].b;
            end
            sprc_pkg::CMD_PIXEL: begin
               w.pix_row               = rows[i].a[sprc_pkg::PIX_W-1:0];
               w.pix_col               = rows[i].b[sprc_pkg::PIX_W-1:0];
               w.color_index           = rows[i].color_index;
               {w.red, w.green, w.blue} = rows[i].rgb;
            end
            sprc_pkg::CMD_READ: begin
               w.read_row = rows[i].a;
               w.read_col = rows[i].b;
            end
            default: ;
         endcase
         send_word(w, rows[i].typed, rows[i].want);
      end

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0:       settle_and_write('0, '0, '0);
            1:       settle_and_write('1, '1, '1);
            default: settle_and_write(sprc_pkg::COLOR_W'($urandom),
                                      sprc_pkg::COLOR_W'($urandom),
                                      sprc_pkg::COLOR_W'($urandom));
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            no_stall = (n >= 120 && n < 180);
            send_word(draw_command(), 1'b0, NO_WANT);
         end
         no_stall = 1'b0;
      end

      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

>>> files.f
rtl/sprc_pkg.sv
rtl/sprc_ram.sv
rtl/sprc_queue.sv
rtl/sprc_front.sv
rtl/sprc_back.sv
rtl/sprite_compositor_with_bounding_box_unit.sv
verif/sprite_compositor_with_bounding_box_unit_tb.sv
